// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Concurrent assertion on clk and rst_n.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK_RST(label, clk, rst_n, prop, msg)

`endif

// ===== rtl/core/swct_pkg.sv =====
// Types, codes and sizes for the stop-and-wait connection table core.
package swct_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HEADER_BYTES = 16;
    localparam int SEQ_MOD      = 255;
    localparam logic [7:0] SEQ_NONE = 8'd254;

    typedef enum logic [1:0] {
        FUNC_REQUEST = 2'd0,
        FUNC_PACKET  = 2'd1,
        FUNC_CLOSE   = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    localparam logic [2:0] FLAG_REQUEST   = 3'd0;
    localparam logic [2:0] FLAG_DATA      = 3'd1;
    localparam logic [2:0] FLAG_ACK       = 3'd2;
    localparam logic [2:0] FLAG_TERMINATE = 3'd3;

    localparam logic [1:0] CHOICE_ACCEPT = 2'd0;
    localparam logic [1:0] CHOICE_FULL   = 2'd1;

    typedef enum logic [3:0] {
        KIND_REQ_PENDING = 4'd0,
        KIND_NEW_DATA    = 4'd1,
        KIND_DUPLICATE   = 4'd2,
        KIND_ACK         = 4'd3,
        KIND_TERMINATE   = 4'd4,
        KIND_UNKNOWN     = 4'd5,
        KIND_ACCEPTED    = 4'd6,
        KIND_DENIED      = 4'd7,
        KIND_CLOSED      = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        RFLAG_ACCEPT = 2'd0,
        RFLAG_DENY   = 2'd1,
        RFLAG_ACK    = 2'd2
    } rflag_t;

    typedef enum logic [1:0] {
        RSN_NONE    = 2'd0,
        RSN_ID_USED = 2'd1,
        RSN_FULL    = 2'd2,
        RSN_REFUSED = 2'd3
    } reason_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  flag_code;
        logic [31:0] peer_id;
        logic [7:0]  seq_num;
        logic [7:0]  ack_num;
        logic [15:0] total_len;
        logic [1:0]  accept_choice;
        logic [31:0] grant_id;
        logic [3:0]  slot_sel;
    } item_t;

    typedef struct packed {
        logic [31:0] peer_id;
        logic [31:0] own_id;
        logic [7:0]  recv_seq;
        logic [7:0]  ack_seq;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic        reply_valid;
        rflag_t      reply_flag;
        logic [7:0]  reply_ack_seq;
        reason_t     reply_reason;
        logic [31:0] reply_own_id;
        logic [31:0] reply_peer_id;
        logic [15:0] payload_len;
        logic [3:0]  conn_slot;
    } result_t;

endpackage

// ===== rtl/core/stop_and_wait_connection_table_core.sv =====
// Receive-side stop-and-wait engine with a scanned connection table.
//
// Usage: one request enters on item_valid/item_stall (request, packet or close),
// one result leaves on result_valid/result_stall. A request is taken when valid
// is high and stall is low. item_stall is high while a request is in work.
// Close, refused or malformed requests and packets flagged as requests go from
// acceptance straight to the result stage. Requests to accept and packets scan the
// table one slot per cycle through the table memory read port, then resolve
// and update: packets from a known sender pass scan, resolve, apply and emit;
// requests to accept and packets from unknown senders skip apply. The next
// request is taken in the cycle after the result is loaded. Unused func codes
// are dropped with no result.
// The result sits in an output register; a stalled result holds, and the
// engine may take one more request meanwhile, waiting before its own result.
// Reset clears all slot valid bits and empties the output register; table
// contents are not cleared and are read only for valid slots.
module stop_and_wait_connection_table_core
    import swct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  func,
    input  logic [2:0]  flag_code,
    input  logic [31:0] peer_id,
    input  logic [7:0]  seq_num,
    input  logic [7:0]  ack_num,
    input  logic [15:0] total_len,
    input  logic [1:0]  accept_choice,
    input  logic [31:0] grant_id,
    input  logic [3:0]  slot_sel,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  kind,
    output logic        reply_valid,
    output logic [1:0]  reply_flag,
    output logic [7:0]  reply_ack_seq,
    output logic [1:0]  reply_reason,
    output logic [31:0] reply_own_id,
    output logic [31:0] reply_peer_id,
    output logic [15:0] payload_len,
    output logic [3:0]  conn_slot
);

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_W:0]       cnt_reg, cnt_next;
    logic                  rd_live_reg, rd_live_next;
    logic [SLOT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [SLOTS-1:0]      valid_reg, valid_next;

    entry_t                mem [SLOTS];
    entry_t                rd_entry_reg;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    entry_t                wr_data;

    logic                  sel_ok;
    logic [SLOT_W-1:0]     sel_idx;
    logic [7:0]            expect_seq;
    logic [7:0]            recv_inc;
    logic [7:0]            recv_new;
    logic [16:0]           len_diff;

    function automatic logic [7:0] seq_inc(input logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, v} + 9'd1;
        if (s >= 9'(SEQ_MOD))
        begin
            s = s - 9'(SEQ_MOD);
        end
        return s[7:0];
    endfunction

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign kind          = out_reg.kind;
    assign reply_valid   = out_reg.reply_valid;
    assign reply_flag    = out_reg.reply_flag;
    assign reply_ack_seq = out_reg.reply_ack_seq;
    assign reply_reason  = out_reg.reply_reason;
    assign reply_own_id  = out_reg.reply_own_id;
    assign reply_peer_id = out_reg.reply_peer_id;
    assign payload_len   = out_reg.payload_len;
    assign conn_slot     = out_reg.conn_slot;

    assign sel_ok     = (32'(item_reg.slot_sel) < SLOTS);
    assign sel_idx    = SLOT_W'(item_reg.slot_sel);
    assign expect_seq = seq_inc(rd_entry_reg.ack_seq);
    assign recv_inc   = seq_inc(rd_entry_reg.recv_seq);
    assign recv_new   = (item_reg.seq_num == expect_seq) ? recv_inc : rd_entry_reg.recv_seq;
    assign len_diff   = {1'b0, item_reg.total_len} - 17'(HEADER_BYTES);

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rd_live_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rd_live_reg   <= rd_live_next;
            rd_idx_reg    <= rd_idx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            valid_reg     <= valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        cnt_next       = cnt_reg;
        rd_live_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        valid_next     = valid_reg;
        rd_addr        = cnt_reg[SLOT_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = sel_idx;
        wr_data        = rd_entry_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = '{func: func, flag_code: flag_code, peer_id: peer_id,
                                  seq_num: seq_num, ack_num: ack_num,
                                  total_len: total_len, accept_choice: accept_choice,
                                  grant_id: grant_id, slot_sel: slot_sel};
                    res_next = '0;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    case (func_t'(func))
                        FUNC_REQUEST:
                        begin
                            if (flag_code != FLAG_REQUEST)
                            begin
                                res_next.kind = KIND_DENIED;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                res_next.reply_valid   = 1'b1;
                                res_next.reply_own_id  = grant_id;
                                res_next.reply_peer_id = peer_id;
                                res_next.kind          = KIND_DENIED;
                                res_next.reply_flag    = RFLAG_DENY;
                                if (accept_choice == CHOICE_ACCEPT)
                                begin
                                    state_next = ST_SCAN;
                                end
                                else
                                begin
                                    res_next.reply_reason = (accept_choice == CHOICE_FULL) ?
                                                            RSN_FULL : RSN_REFUSED;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        FUNC_PACKET:
                        begin
                            if (flag_code == FLAG_REQUEST)
                            begin
                                res_next.kind = KIND_REQ_PENDING;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_CLOSE:
                        begin
                            if (32'(slot_sel) < SLOTS)
                            begin
                                valid_next[SLOT_W'(slot_sel)] = 1'b0;
                            end
                            res_next.kind      = KIND_CLOSED;
                            res_next.conn_slot = slot_sel;
                            state_next         = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read slot cnt, compare the previously read slot
                if (cnt_reg < (SLOT_W + 1)'(SLOTS))
                begin
                    rd_live_next = 1'b1;
                    rd_idx_next  = cnt_reg[SLOT_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_RESOLVE;
                end
                if (rd_live_reg && valid_reg[rd_idx_reg] &&
                    rd_entry_reg.peer_id == item_reg.peer_id)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
            end

            ST_RESOLVE:
            begin
                rd_addr = hit_idx_reg;
                if (item_reg.func == FUNC_REQUEST)
                begin
                    state_next = ST_EMIT;
                    if (hit_reg)
                    begin
                        res_next.reply_reason = RSN_ID_USED;
                        res_next.conn_slot    = 4'(hit_idx_reg);
                    end
                    else if (!sel_ok)
                    begin
                        res_next.reply_reason = RSN_FULL;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{peer_id: item_reg.peer_id, own_id: item_reg.grant_id,
                                    recv_seq: SEQ_NONE, ack_seq: SEQ_NONE};
                        valid_next[sel_idx] = 1'b1;
                        res_next.kind       = KIND_ACCEPTED;
                        res_next.reply_flag = RFLAG_ACCEPT;
                        res_next.conn_slot  = item_reg.slot_sel;
                    end
                end
                else if (!hit_reg)
                begin
                    res_next.kind = KIND_UNKNOWN;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                wr_addr            = hit_idx_reg;
                res_next.conn_slot = 4'(hit_idx_reg);
                state_next         = ST_EMIT;
                case (item_reg.flag_code)
                    FLAG_DATA:
                    begin
                        wr_en            = 1'b1;
                        wr_data.recv_seq = recv_new;
                        wr_data.ack_seq  = recv_new;
                        if (item_reg.seq_num == expect_seq)
                        begin
                            res_next.kind        = KIND_NEW_DATA;
                            res_next.payload_len = len_diff[16] ? 16'd0 : len_diff[15:0];
                        end
                        else
                        begin
                            res_next.kind = KIND_DUPLICATE;
                        end
                        res_next.reply_valid   = 1'b1;
                        res_next.reply_flag    = RFLAG_ACK;
                        res_next.reply_ack_seq = recv_new;
                        res_next.reply_own_id  = rd_entry_reg.own_id;
                        res_next.reply_peer_id = rd_entry_reg.peer_id;
                    end
                    FLAG_ACK:
                    begin
                        wr_en           = 1'b1;
                        wr_data.ack_seq = item_reg.ack_num;
                        res_next.kind   = KIND_ACK;
                    end
                    FLAG_TERMINATE:
                    begin
                        res_next.kind = KIND_TERMINATE;
                    end
                    default:
                    begin
                        res_next.kind = KIND_UNKNOWN;
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/swct_checker.sv =====
// Port-level checks for the stop-and-wait connection table core, with bind.
`include "assert_macros.svh"

module swct_checker
    import swct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [3:0]  kind,
    input logic        reply_valid,
    input logic [1:0]  reply_flag,
    input logic [7:0]  reply_ack_seq,
    input logic [1:0]  reply_reason,
    input logic [15:0] payload_len,
    input logic [3:0]  conn_slot
);

    `ASSERT_STD(a_accept_reply, result_valid && kind == KIND_ACCEPTED |-> reply_valid && reply_flag == RFLAG_ACCEPT && reply_reason == RSN_NONE, "accepted without accept reply")
    `ASSERT_STD(a_len_only_data, result_valid && kind != KIND_NEW_DATA |-> payload_len == 16'd0, "payload length outside new data")
    `ASSERT_STD(a_data_acked, result_valid && (kind == KIND_NEW_DATA || kind == KIND_DUPLICATE) |-> reply_valid && reply_flag == RFLAG_ACK && reply_ack_seq != 8'd255, "data without valid ack reply")
    `ASSERT_STD(a_stall_hold, result_valid && result_stall |=> result_valid && $stable(kind) && $stable(conn_slot), "stalled result changed")

endmodule

bind stop_and_wait_connection_table_core swct_checker u_swct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .reply_valid   (reply_valid),
    .reply_flag    (reply_flag),
    .reply_ack_seq (reply_ack_seq),
    .reply_reason  (reply_reason),
    .payload_len   (payload_len),
    .conn_slot     (conn_slot)
);

// ===== tb/tb_stop_and_wait_connection_table_core.sv =====
// Testbench for the stop-and-wait connection table core: driver, monitor and predictor.
module tb_stop_and_wait_connection_table_core;
    import swct_pkg::*;

    localparam int CHK_COPY = 0;
    localparam int GEN_COPY = 1;
    localparam int POOL = 24;
    localparam int RAND_ITEMS = 1780;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 600000;
    localparam logic [2:0] FLAG_FIRST_UNKNOWN = 3'd4;
    localparam logic [2:0] FLAG_LAST_UNKNOWN = 3'd7;
    localparam logic [1:0] CHOICE_REFUSE = 2'd2;
    localparam logic [1:0] CHOICE_REFUSE_ALT = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [1:0]  func = '0;
    logic [2:0]  flag_code = '0;
    logic [31:0] peer_id = '0;
    logic [7:0]  seq_num = '0;
    logic [7:0]  ack_num = '0;
    logic [15:0] total_len = '0;
    logic [1:0]  accept_choice = '0;
    logic [31:0] grant_id = '0;
    logic [3:0]  slot_sel = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [3:0]  kind;
    logic        reply_valid;
    logic [1:0]  reply_flag;
    logic [7:0]  reply_ack_seq;
    logic [1:0]  reply_reason;
    logic [31:0] reply_own_id;
    logic [31:0] reply_peer_id;
    logic [15:0] payload_len;
    logic [3:0]  conn_slot;

    // two copies of the connection table: one for checking, one for steering stimulus
    bit          tbl_valid [2][SLOTS];
    logic [31:0] tbl_peer [2][SLOTS];
    logic [31:0] tbl_own [2][SLOTS];
    logic [7:0]  tbl_recv [2][SLOTS];
    logic [7:0]  tbl_ack [2][SLOTS];

    logic [31:0] peer_pool [POOL];
    item_t       pending [$];
    result_t     expected [$];
    item_t       cur_item;
    result_t     exp_res;
    result_t     gen_scratch;
    bit          hold;
    int          n_taken = 0;
    int          n_accepted = 0;
    int          n_total = 0;
    int          n_directed = 0;
    int          n_results = 0;
    int          n_errors = 0;
    longint      n_cycles = 0;

    stop_and_wait_connection_table_core dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int find_peer(input int cp, input logic [31:0] id);
        int hit;
        hit = -1;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[cp][i] && tbl_peer[cp][i] == id)
                hit = i;
        return hit;
    endfunction

    // returns 1 when the request produces a result
    function automatic bit predict_result(input int cp, input item_t it, output result_t r);
        int hit;
        int unsigned nxt;
        r = '0;
        if (it.func == FUNC_UNUSED)
            return 1'b0;
        if (it.func == FUNC_CLOSE)
        begin
            if (int'(it.slot_sel) < SLOTS)
                tbl_valid[cp][it.slot_sel] = 1'b0;
            r.kind = KIND_CLOSED;
            r.conn_slot = it.slot_sel;
            return 1'b1;
        end
        if (it.func == FUNC_REQUEST)
        begin
            r.kind = KIND_DENIED;
            if (it.flag_code != FLAG_REQUEST)
                return 1'b1;
            r.reply_valid = 1'b1;
            r.reply_flag = RFLAG_DENY;
            r.reply_own_id = it.grant_id;
            r.reply_peer_id = it.peer_id;
            if (it.accept_choice == CHOICE_FULL)
                r.reply_reason = RSN_FULL;
            else if (it.accept_choice != CHOICE_ACCEPT)
                r.reply_reason = RSN_REFUSED;
            else
            begin
                hit = find_peer(cp, it.peer_id);
                if (hit >= 0)
                begin
                    r.reply_reason = RSN_ID_USED;
                    r.conn_slot = hit[3:0];
                end
                else if (int'(it.slot_sel) >= SLOTS)
                    r.reply_reason = RSN_FULL;
                else
                begin
                    tbl_valid[cp][it.slot_sel] = 1'b1;
                    tbl_peer[cp][it.slot_sel] = it.peer_id;
                    tbl_own[cp][it.slot_sel] = it.grant_id;
                    tbl_recv[cp][it.slot_sel] = SEQ_NONE;
                    tbl_ack[cp][it.slot_sel] = SEQ_NONE;
                    r.kind = KIND_ACCEPTED;
                    r.reply_flag = RFLAG_ACCEPT;
                    r.conn_slot = it.slot_sel;
                end
            end
            return 1'b1;
        end
        if (it.flag_code == FLAG_REQUEST)
        begin
            r.kind = KIND_REQ_PENDING;
            return 1'b1;
        end
        hit = find_peer(cp, it.peer_id);
        if (hit < 0)
        begin
            r.kind = KIND_UNKNOWN;
            return 1'b1;
        end
        r.conn_slot = hit[3:0];
        case (it.flag_code)
            FLAG_DATA:
            begin
                nxt = (tbl_ack[cp][hit] + 32'd1) % SEQ_MOD;
                if (it.seq_num == nxt)
                begin
                    nxt = (tbl_recv[cp][hit] + 32'd1) % SEQ_MOD;
                    tbl_recv[cp][hit] = nxt[7:0];
                    r.kind = KIND_NEW_DATA;
                    if (it.total_len > HEADER_BYTES)
                        r.payload_len = 16'(it.total_len - HEADER_BYTES);
                end
                else
                    r.kind = KIND_DUPLICATE;
                tbl_ack[cp][hit] = tbl_recv[cp][hit];
                r.reply_valid = 1'b1;
                r.reply_flag = RFLAG_ACK;
                r.reply_ack_seq = tbl_ack[cp][hit];
                r.reply_own_id = tbl_own[cp][hit];
                r.reply_peer_id = tbl_peer[cp][hit];
            end
            FLAG_ACK:
            begin
                tbl_ack[cp][hit] = it.ack_num;
                r.kind = KIND_ACK;
            end
            FLAG_TERMINATE:
                r.kind = KIND_TERMINATE;
            default:
                r.kind = KIND_UNKNOWN;
        endcase
        return 1'b1;
    endfunction

    function automatic void add_item(input item_t it);
        pending.push_back(it);
        void'(predict_result(GEN_COPY, it, gen_scratch));
    endfunction

    function automatic void add_directed(input logic [1:0] f, input logic [2:0] flag,
                                         input logic [31:0] peer, input logic [7:0] seq,
                                         input logic [7:0] ackv, input logic [15:0] len,
                                         input logic [1:0] choice, input logic [3:0] sel);
        item_t it;
        it = '0;
        it.func = f;
        it.flag_code = flag;
        it.peer_id = peer;
        it.seq_num = seq;
        it.ack_num = ackv;
        it.total_len = len;
        it.accept_choice = choice;
        it.grant_id = $urandom;
        it.slot_sel = sel;
        add_item(it);
    endfunction

    // mostly well-formed traffic on live connections, with some noise
    function automatic item_t rand_item();
        item_t it;
        int pick;
        int s;
        int live [$];
        int unsigned nxt;
        it = '0;
        it.flag_code = 3'($urandom);
        it.peer_id = $urandom;
        it.seq_num = 8'($urandom);
        it.ack_num = 8'($urandom);
        it.total_len = 16'($urandom);
        it.accept_choice = 2'($urandom);
        it.grant_id = $urandom;
        it.slot_sel = 4'($urandom);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[GEN_COPY][i])
                live.push_back(i);
        s = (live.size() == 0) ? -1 : live[$urandom_range(0, live.size() - 1)];
        pick = $urandom_range(0, 99);
        if (pick >= 16 && pick < 78 && s < 0)
            pick = 0;
        it.func = FUNC_PACKET;
        if (s >= 0)
            it.peer_id = tbl_peer[GEN_COPY][s];
        if (pick < 16)
        begin
            it.func = FUNC_REQUEST;
            if ($urandom_range(0, 99) < 92)
                it.flag_code = FLAG_REQUEST;
            it.peer_id = ($urandom_range(0, 99) < 75) ? peer_pool[$urandom_range(0, POOL - 1)]
                                                      : $urandom;
            if ($urandom_range(0, 99) < 75)
                it.accept_choice = CHOICE_ACCEPT;
        end
        else if (pick < 60)
        begin
            it.flag_code = FLAG_DATA;
            if ($urandom_range(0, 99) < 75)
            begin
                nxt = (tbl_ack[GEN_COPY][s] + 32'd1) % SEQ_MOD;
                it.seq_num = nxt[7:0];
            end
            case ($urandom_range(0, 3))
                0: it.total_len = 16'($urandom_range(0, 32));
                1: it.total_len = 16'hFFFF;
                default: it.total_len = 16'($urandom_range(0, 65535));
            endcase
        end
        else if (pick < 70)
        begin
            it.flag_code = FLAG_ACK;
            if ($urandom_range(0, 1) == 0)
                it.ack_num = tbl_recv[GEN_COPY][s];
        end
        else if (pick < 74)
            it.flag_code = FLAG_TERMINATE;
        else if (pick < 78)
            it.flag_code = 3'($urandom_range(FLAG_FIRST_UNKNOWN, FLAG_LAST_UNKNOWN));
        else if (pick < 82)
            it.flag_code = FLAG_REQUEST;
        else if (pick < 88)
            it.peer_id = ($urandom_range(0, 1) == 0) ? peer_pool[$urandom_range(0, POOL - 1)]
                                                     : $urandom;
        else if (pick < 96)
        begin
            it.func = FUNC_CLOSE;
            if (s >= 0 && $urandom_range(0, 1) == 0)
                it.slot_sel = s[3:0];
        end
        else
            it.func = FUNC_UNUSED;
        return it;
    endfunction

    function automatic int idle_pct(input bit rx_side);
        case ((n_taken * 3) / n_total)
            0: return rx_side ? 47 : 19;
            1: return rx_side ? 19 : 47;
            default: return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("result %0d: %s expected %0h got %0h", n_results, name, want, got);
        end
    endtask

    initial
    begin
        logic [31:0] p1;
        int n_rand;
        item_t it;
        p1 = $urandom;
        peer_pool[0] = 32'h0;
        peer_pool[1] = 32'hFFFF_FFFF;
        peer_pool[2] = p1;
        for (int i = 3; i < POOL; i++)
            peer_pool[i] = $urandom;

        add_directed(FUNC_CLOSE, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd0, 8'd0, 16'd100, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_TERMINATE, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_FULL, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_REFUSE, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_REFUSE_ALT, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd5);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd0, 8'd0, 16'd16, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd1, 8'd0, 16'd17, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd2, 8'd0, 16'hFFFF, CHOICE_ACCEPT, 4'd0);
        // ack wraps: 254 expects 0 next, 255 expects 1 next
        add_directed(FUNC_PACKET, FLAG_ACK, p1, 8'd0, 8'd254, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd0, 8'd0, 16'd40, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_ACK, p1, 8'd0, 8'd255, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd1, 8'd0, 16'd20, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_TERMINATE, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_FIRST_UNKNOWN, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT,
                     4'd0);
        add_directed(FUNC_PACKET, FLAG_LAST_UNKNOWN, p1, 8'hFF, 8'hFF, 16'hFFFF,
                     CHOICE_REFUSE_ALT, 4'd15);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                     CHOICE_ACCEPT, 4'd15);
        add_directed(FUNC_REQUEST, FLAG_REQUEST, 32'h0, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd15);
        add_directed(FUNC_PACKET, FLAG_DATA, 32'hFFFF_FFFF, 8'd0, 8'd0, 16'd50, CHOICE_ACCEPT,
                     4'd0);
        add_directed(FUNC_UNUSED, FLAG_DATA, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_CLOSE, FLAG_REQUEST, p1, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_PACKET, FLAG_DATA, p1, 8'd2, 8'd0, 16'd30, CHOICE_ACCEPT, 4'd0);
        add_directed(FUNC_CLOSE, FLAG_REQUEST, 32'h0, 8'd0, 8'd0, 16'd0, CHOICE_ACCEPT, 4'd15);
        n_directed = pending.size();

        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            it = rand_item();
            add_item(it);
            if (it.func != FUNC_UNUSED)
                n_rand++;
        end
        n_total = pending.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge clk);
        while (expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && expected.size() == 0)
            $display("stop_and_wait_connection_table_core verification clean");
        else
            $display("stop_and_wait_connection_table_core verification failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            func <= '0;
            flag_code <= '0;
            peer_id <= '0;
            seq_num <= '0;
            ack_num <= '0;
            total_len <= '0;
            accept_choice <= '0;
            grant_id <= '0;
            slot_sel <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                if (predict_result(CHK_COPY, cur_item, exp_res))
                    expected.push_back(exp_res);
                n_accepted++;
            end
            if (!item_valid || !item_stall)
            begin
                // hold off at the end of the directed part and midway until drained
                hold = (pending.size() == 0) || ($urandom_range(0, 99) < idle_pct(1'b0))
                       || ((n_taken == n_directed || n_taken == n_total / 2)
                           && expected.size() != 0);
                if (hold)
                    item_valid <= 1'b0;
                else
                begin
                    cur_item = pending.pop_front();
                    n_taken++;
                    item_valid <= 1'b1;
                    func <= cur_item.func;
                    flag_code <= cur_item.flag_code;
                    peer_id <= cur_item.peer_id;
                    seq_num <= cur_item.seq_num;
                    ack_num <= cur_item.ack_num;
                    total_len <= cur_item.total_len;
                    accept_choice <= cur_item.accept_choice;
                    grant_id <= cur_item.grant_id;
                    slot_sel <= cur_item.slot_sel;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (expected.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d: kind %0d with no request pending", n_results,
                                 kind);
                end
                else
                begin
                    exp_res = expected.pop_front();
                    check_field("kind", 32'(exp_res.kind), 32'(kind));
                    check_field("reply_valid", 32'(exp_res.reply_valid), 32'(reply_valid));
                    check_field("reply_flag", 32'(exp_res.reply_flag), 32'(reply_flag));
                    check_field("reply_ack_seq", 32'(exp_res.reply_ack_seq),
                                32'(reply_ack_seq));
                    check_field("reply_reason", 32'(exp_res.reply_reason), 32'(reply_reason));
                    check_field("reply_own_id", exp_res.reply_own_id, reply_own_id);
                    check_field("reply_peer_id", exp_res.reply_peer_id, reply_peer_id);
                    check_field("payload_len", 32'(exp_res.payload_len), 32'(payload_len));
                    check_field("conn_slot", 32'(exp_res.conn_slot), 32'(conn_slot));
                end
            end
            result_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("stop_and_wait_connection_table_core verification failed");
            $finish;
        end
    end

endmodule
